// ===== design/task_slot_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Task slot scheduler assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TASK_SLOT_SCHEDULER_MACROS_SVH
`define TASK_SLOT_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold starting in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler package
// Command and result payload types, slot entry layout, controller states.
// ----------------------------------------------------------------------------
package tss_pkg;

    // Command codes carried in the input transfer.
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_e;

    // Input payload.
    typedef struct packed {
        cmd_e        command;
        logic [2:0]  slot;
        logic [7:0]  task_handle;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
    } cmd_t;

    // Result payload.
    typedef struct packed {
        logic       status;
        logic [2:0] result_slot;
        logic [7:0] run_handle;
        logic       run_valid;
        logic       last_result;
    } result_t;

    // One word of the slot memory.
    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } entry_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_OUT,
        ST_DEL,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_DSP_PRIME,
        ST_DSP_SCAN,
        ST_DSP_FLUSH
    } state_e;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // A dispatch names at most this many tasks.
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    localparam logic [7:0] PENDING_MAX = 8'hFF;

endpackage

// ===== design/tss_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Task slot memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tss_slot_mem #(
    parameter int SLOTS = 8
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  tss_pkg::entry_t                      wdata,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] raddr,
    output tss_pkg::entry_t                      rdata
);

    tss_pkg::entry_t mem_reg [SLOTS];
    tss_pkg::entry_t rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tss_out_buf.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler output register
// Holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module tss_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tss_pkg::result_t push_data,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output tss_pkg::result_t m_data
);

    logic             valid_reg;
    logic             valid_next;
    tss_pkg::result_t data_reg;

    // The register can load when empty or when its result leaves this cycle.
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = push ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== design/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler controller
// Sequences add, delete, tick and dispatch over the slot memory.
// ----------------------------------------------------------------------------
module tss_ctrl #(
    parameter int SLOTS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tss_pkg::cmd_t                        s_data,
    output logic                                 mem_we,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] mem_waddr,
    output tss_pkg::entry_t                      mem_wdata,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] mem_raddr,
    input  tss_pkg::entry_t                      rd_data,
    output logic                                 push,
    output tss_pkg::result_t                     push_data,
    input  logic                                 out_free
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    tss_pkg::state_e             state_reg, state_next;
    tss_pkg::cmd_t               cmd_reg;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        full_reg, full_next;
    logic [tss_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        cand_valid_reg, cand_valid_next;
    logic [IDX_W-1:0]            cand_slot_reg, cand_slot_next;
    logic [7:0]                  cand_handle_reg, cand_handle_next;
    logic [SLOTS-1:0]            valid_reg, valid_next;

    logic                        accept;
    logic                        slot_ok;
    logic [IDX_W-1:0]            slot_idx;
    logic                        hit;
    logic                        at_end;
    logic                        last_hit;

    assign s_ready = (state_reg == tss_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Slot field of the held command, checked against the table size.
    assign slot_ok  = (32'(cmd_reg.slot) < SLOTS);
    assign slot_idx = IDX_W'(32'(cmd_reg.slot));

    // Dispatch scan: read data belongs to the slot at idx_reg.
    assign hit    = valid_reg[idx_reg] && (rd_data.pending != 8'd0);
    assign at_end = (idx_reg == LAST_IDX);

    // The current hit ends the scan when the result limit or the last slot is reached.
    assign last_hit = (cnt_reg == tss_pkg::CNT_W'(tss_pkg::MAX_RESULTS - 1)) || at_end;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tss_pkg::ST_IDLE;
            idx_reg        <= '0;
            full_reg       <= 1'b0;
            cnt_reg        <= '0;
            cand_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            full_reg       <= full_next;
            cnt_reg        <= cnt_next;
            cand_valid_reg <= cand_valid_next;
            valid_reg      <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_data;
        end
        cand_slot_reg   <= cand_slot_next;
        cand_handle_reg <= cand_handle_next;
    end

    // Next state, memory accesses and result pushes.
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        full_next        = full_reg;
        cnt_next         = cnt_reg;
        cand_valid_next  = cand_valid_reg;
        cand_slot_next   = cand_slot_reg;
        cand_handle_next = cand_handle_reg;
        valid_next       = valid_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = rd_data;
        mem_raddr        = idx_reg;
        push             = 1'b0;
        push_data        = '0;

        unique case (state_reg)
            tss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    idx_next        = '0;
                    cnt_next        = '0;
                    cand_valid_next = 1'b0;
                    unique case (s_data.command)
                        tss_pkg::CMD_ADD:      state_next = tss_pkg::ST_ADD_SCAN;
                        tss_pkg::CMD_DELETE:   state_next = tss_pkg::ST_DEL;
                        tss_pkg::CMD_TICK:     state_next = tss_pkg::ST_TICK_RD;
                        tss_pkg::CMD_DISPATCH: state_next = tss_pkg::ST_DSP_PRIME;
                    endcase
                end
            end

            // Look for the lowest free slot, one slot per cycle.
            tss_pkg::ST_ADD_SCAN: begin
                if (!valid_reg[idx_reg]) begin
                    full_next  = 1'b0;
                    state_next = tss_pkg::ST_ADD_OUT;
                end else if (at_end) begin
                    full_next  = 1'b1;
                    state_next = tss_pkg::ST_ADD_OUT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Store the task and report the slot taken, or report a full table.
            tss_pkg::ST_ADD_OUT: begin
                if (out_free) begin
                    push                  = 1'b1;
                    push_data.last_result = 1'b1;
                    if (full_reg) begin
                        push_data.status = tss_pkg::STATUS_FAIL;
                    end else begin
                        push_data.status      = tss_pkg::STATUS_OK;
                        push_data.result_slot = 3'(32'(idx_reg));
                        mem_we                = 1'b1;
                        mem_waddr             = idx_reg;
                        mem_wdata.handle      = cmd_reg.task_handle;
                        mem_wdata.delay       = cmd_reg.start_delay;
                        mem_wdata.period      = cmd_reg.repeat_period;
                        mem_wdata.pending     = 8'd0;
                        valid_next[idx_reg]   = 1'b1;
                    end
                    state_next = tss_pkg::ST_IDLE;
                end
            end

            // Free the slot; an empty or nonexistent slot reports a failure.
            tss_pkg::ST_DEL: begin
                if (out_free) begin
                    push                  = 1'b1;
                    push_data.result_slot = cmd_reg.slot;
                    push_data.last_result = 1'b1;
                    if (slot_ok) begin
                        push_data.status     = valid_reg[slot_idx] ? tss_pkg::STATUS_OK
                                                                   : tss_pkg::STATUS_FAIL;
                        valid_next[slot_idx] = 1'b0;
                    end else begin
                        push_data.status = tss_pkg::STATUS_FAIL;
                    end
                    state_next = tss_pkg::ST_IDLE;
                end
            end

            tss_pkg::ST_TICK_RD: begin
                mem_raddr  = slot_idx;
                state_next = tss_pkg::ST_TICK_WR;
            end

            // Count down the delay, or count a run and reload the delay.
            tss_pkg::ST_TICK_WR: begin
                if (slot_ok && valid_reg[slot_idx]) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_idx;
                    if (rd_data.delay == 16'd0) begin
                        if (rd_data.pending != tss_pkg::PENDING_MAX) begin
                            mem_wdata.pending = rd_data.pending + 8'd1;
                        end
                        if (rd_data.period != 16'd0) begin
                            mem_wdata.delay = rd_data.period;
                        end
                    end else begin
                        mem_wdata.delay = rd_data.delay - 16'd1;
                    end
                end
                state_next = tss_pkg::ST_IDLE;
            end

            tss_pkg::ST_DSP_PRIME: begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = tss_pkg::ST_DSP_SCAN;
            end

            // Scan the slots; each hit is held until the next one shows
            // whether it is the last result of the dispatch.
            tss_pkg::ST_DSP_SCAN: begin
                if (hit) begin
                    if (cand_valid_reg && !out_free) begin
                        mem_raddr = idx_reg;
                    end else begin
                        if (cand_valid_reg) begin
                            push                  = 1'b1;
                            push_data.status      = tss_pkg::STATUS_OK;
                            push_data.result_slot = 3'(32'(cand_slot_reg));
                            push_data.run_handle  = cand_handle_reg;
                            push_data.run_valid   = 1'b1;
                        end
                        cand_valid_next   = 1'b1;
                        cand_slot_next    = idx_reg;
                        cand_handle_next  = rd_data.handle;
                        mem_we            = 1'b1;
                        mem_waddr         = idx_reg;
                        mem_wdata.pending = rd_data.pending - 8'd1;
                        cnt_next          = cnt_reg + tss_pkg::CNT_W'(1);
                        if (last_hit) begin
                            state_next = tss_pkg::ST_DSP_FLUSH;
                        end else begin
                            idx_next  = idx_reg + IDX_W'(1);
                            mem_raddr = idx_reg + IDX_W'(1);
                        end
                    end
                end else if (at_end) begin
                    state_next = tss_pkg::ST_DSP_FLUSH;
                end else begin
                    idx_next  = idx_reg + IDX_W'(1);
                    mem_raddr = idx_reg + IDX_W'(1);
                end
            end

            // Send the held hit as the last result, or an empty result.
            tss_pkg::ST_DSP_FLUSH: begin
                if (out_free) begin
                    push                  = 1'b1;
                    push_data.last_result = 1'b1;
                    if (cand_valid_reg) begin
                        push_data.result_slot = 3'(32'(cand_slot_reg));
                        push_data.run_handle  = cand_handle_reg;
                        push_data.run_valid   = 1'b1;
                    end
                    cand_valid_next = 1'b0;
                    state_next      = tss_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/task_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler
// Cooperative scheduler over a table of task slots kept in one memory.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_ channel (valid/ready) and results leave on
// the m_ channel (valid/ready), one struct per transfer. A command is taken
// only while the controller is idle; a result waiting in the output register
// does not keep the next command out until that command has a result to send.
// Steps per command, up to the result being loaded into the output register:
//   add       scan of the valid bits, one slot checked a cycle, then one result
//   delete    one result
//   tick      memory read, then write back, no result
//   dispatch  scan, one memory entry read a cycle unless a held hit waits for
//             the output register, up to 8 results, the last marked by last_result
// After the last result is loaded, the next command can be taken in the following cycle.
// Reset clears the valid bit of every slot; an invalid slot reads as empty,
// so no clearing pass over the memory is needed.
// When the receiver stalls, the output register holds its result and the
// controller waits before loading the next one, keeping every result.
// ----------------------------------------------------------------------------
module task_slot_scheduler #(
    parameter int SLOTS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tss_pkg::cmd_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tss_pkg::result_t m_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    tss_pkg::entry_t  mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    tss_pkg::entry_t  rd_data;
    logic             push;
    tss_pkg::result_t push_data;
    logic             out_free;

    // Command sequencer.
    tss_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .rd_data   (rd_data),
        .push      (push),
        .push_data (push_data),
        .out_free  (out_free)
    );

    // Slot table storage.
    tss_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    // Result register toward the receiver.
    tss_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== design/tss_checker.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "task_slot_scheduler_macros.svh"

module tss_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input tss_pkg::cmd_t    s_data,
    input logic             m_valid,
    input logic             m_ready,
    input tss_pkg::result_t m_data
);

    logic s_xfer;
    logic tick_xfer;
    logic m_stall;
    logic m_fail;
    logic fail_plain;
    logic m_run;

    // Short names for the conditions the assertions watch.
    assign s_xfer     = s_valid && s_ready;
    assign tick_xfer  = s_xfer && !m_valid && (s_data.command == tss_pkg::CMD_TICK);
    assign m_stall    = m_valid && !m_ready;
    assign m_fail     = m_valid && (m_data.status == tss_pkg::STATUS_FAIL);
    assign fail_plain = !m_data.run_valid && (m_data.run_handle == 8'd0) && m_data.last_result;
    assign m_run      = m_valid && m_data.run_valid;

    // A stalled result holds its value.
    `TSS_ASSERT_NEXT(a_result_hold, m_stall, m_valid && $stable(m_data), "stalled result changed")

    // A tick taken while no result is waiting produces no result.
    `TSS_ASSERT_NEXT(a_tick_silent, tick_xfer, !m_valid ##1 !m_valid, "tick produced a result")

    // The controller is busy right after taking a command.
    `TSS_ASSERT_NEXT(a_busy_after_cmd, s_xfer, !s_ready, "command taken on consecutive cycles")

    // A failure is a single plain result.
    `TSS_ASSERT_SAME(a_fail_shape, m_fail, fail_plain, "failure result malformed")

    // A task to run always comes with ok status.
    `TSS_ASSERT_SAME(a_run_ok, m_run, m_data.status == tss_pkg::STATUS_OK, "run result not ok")

endmodule

bind task_slot_scheduler tss_checker u_tss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
